### rtl/bgl_pkg.sv
// Shared constants, result struct and helpers for the BNF grammar lexer.
// No dependencies; imported by every module in rtl/.
package bgl_pkg;

  localparam int unsigned PosBits = 16;   // width of line/column counters (8..32)
  localparam int unsigned OutPosBits = 16;

  // event kinds
  localparam logic [1:0] KindText  = 2'd0;
  localparam logic [1:0] KindDone  = 2'd1;
  localparam logic [1:0] KindError = 2'd2;

  // token types
  localparam logic [2:0] TokBar    = 3'd0;
  localparam logic [2:0] TokSemi   = 3'd1;
  localparam logic [2:0] TokAssign = 3'd2;
  localparam logic [2:0] TokNonterm = 3'd3;
  localparam logic [2:0] TokTerm   = 3'd4;

  // error codes
  localparam logic [2:0] ErrUnexpected = 3'd0;
  localparam logic [2:0] ErrNeedLetter = 3'd1;
  localparam logic [2:0] ErrNeedName   = 3'd2;
  localparam logic [2:0] ErrNeedColon  = 3'd3;
  localparam logic [2:0] ErrNeedEquals = 3'd4;
  localparam logic [2:0] ErrNeedPrint  = 3'd5;
  localparam logic [2:0] ErrBadEscape  = 3'd6;
  localparam logic [2:0] ErrMidToken   = 3'd7;

  // characters
  localparam logic [7:0] ChBar    = 8'h7C;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChLt     = 8'h3C;
  localparam logic [7:0] ChGt     = 8'h3E;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChEquals = 8'h3D;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChUscore = 8'h5F;
  localparam logic [7:0] ChDash   = 8'h2D;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChFf     = 8'h0C;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChVt     = 8'h0B;
  localparam logic [7:0] ChTilde  = 8'h7E;

  localparam int unsigned ResBits = 3 + 8 + 3 + 2 * OutPosBits;
  localparam int unsigned TdataBits = ((ResBits + 7) / 8) * 8;

  typedef struct packed {
    logic [1:0]            kind;
    logic [2:0]            tok_type;
    logic [7:0]            text_char;
    logic [2:0]            err_code;
    logic [OutPosBits-1:0] line;
    logic [OutPosBits-1:0] column;
  } result_t;

  function automatic logic [PosBits-1:0] sat_inc(input logic [PosBits-1:0] v);
    return (&v) ? v : v + PosBits'(1);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

endpackage

### rtl/bgl_in_stage.sv
// Input register of the lexer: holds one accepted byte until the core takes it.
// Depends on bgl_pkg (nothing used beyond the import convention).
module bgl_in_stage import bgl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] char_i,
  input  logic       eoi_i,
  input  logic       take_i,     // core consumes the held item this cycle
  output logic       valid_o,
  output logic [7:0] char_o,
  output logic       eoi_o
);

  logic       valid_q, valid_d;
  logic [7:0] char_q;
  logic       eoi_q;

  assign ready_o = !valid_q || take_i;
  assign valid_d = (valid_i && ready_o) || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      char_q <= char_i;
      eoi_q  <= eoi_i;
    end
  end

  assign valid_o = valid_q;
  assign char_o  = char_q;
  assign eoi_o   = eoi_q;

endmodule

### rtl/bgl_lex_core.sv
// Lexer state machine with line/column counters; one byte per cycle while adv_i is high.
// Depends on bgl_pkg for codes, characters, result_t and helpers.
module bgl_lex_core import bgl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  logic [7:0] char_i,
  input  logic       eoi_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  localparam logic [2:0] ModeIdle    = 3'd0;
  localparam logic [2:0] ModeNtStart = 3'd1;
  localparam logic [2:0] ModeNt      = 3'd2;
  localparam logic [2:0] ModeColon1  = 3'd3;
  localparam logic [2:0] ModeColon2  = 3'd4;
  localparam logic [2:0] ModeTerm    = 3'd5;
  localparam logic [2:0] ModeEscape  = 3'd6;

  logic [2:0]         mode_q, mode_d;
  logic [PosBits-1:0] line_q, line_d;
  logic [PosBits-1:0] col_q, col_d;
  logic [PosBits-1:0] tok_q, tok_d;
  logic [PosBits-1:0] col_inc;
  logic               hit;
  logic [1:0]         kind;
  logic [2:0]         tok_type;
  logic [7:0]         text_char;
  logic [2:0]         err_code;
  logic [PosBits-1:0] res_col;

  assign col_inc = sat_inc(col_q);

  always_comb begin
    mode_d    = mode_q;
    line_d    = line_q;
    col_d     = col_q;
    tok_d     = tok_q;
    hit       = 1'b0;
    kind      = KindError;
    tok_type  = TokBar;
    text_char = char_i;
    err_code  = ErrUnexpected;
    res_col   = col_inc;
    if (eoi_i) begin
      hit       = (mode_q != ModeIdle);
      err_code  = ErrMidToken;
      text_char = 8'h00;
      res_col   = col_q;
      mode_d    = ModeIdle;
      line_d    = PosBits'(1);
      col_d     = '0;
      tok_d     = '0;
    end else begin
      col_d = col_inc;
      unique case (mode_q)
        ModeIdle: begin
          tok_d = col_inc;
          if (char_i == ChBar || char_i == ChSemi) begin
            hit       = 1'b1;
            kind      = KindDone;
            tok_type  = (char_i == ChBar) ? TokBar : TokSemi;
            text_char = 8'h00;
          end else if (char_i == ChLt) begin
            mode_d = ModeNtStart;
          end else if (char_i == ChQuote) begin
            mode_d = ModeTerm;
          end else if (char_i == ChColon) begin
            mode_d = ModeColon1;
          end else if (char_i == ChLf || char_i == ChCr || char_i == ChFf) begin
            line_d = sat_inc(line_q);
            col_d  = '0;
          end else if (!(char_i == ChSpace || char_i == ChTab || char_i == ChVt)) begin
            hit = 1'b1;
          end
        end
        ModeNtStart: begin
          hit = 1'b1;
          if (is_letter(char_i)) begin
            kind     = KindText;
            tok_type = TokNonterm;
            res_col  = tok_q;
            mode_d   = ModeNt;
          end else begin
            err_code = ErrNeedLetter;
          end
        end
        ModeNt: begin
          hit = 1'b1;
          if (char_i == ChGt) begin
            kind      = KindDone;
            tok_type  = TokNonterm;
            text_char = 8'h00;
            res_col   = tok_q;
            mode_d    = ModeIdle;
          end else if (is_letter(char_i) || is_digit(char_i) ||
                       char_i == ChUscore || char_i == ChDash) begin
            kind     = KindText;
            tok_type = TokNonterm;
            res_col  = tok_q;
          end else begin
            err_code = ErrNeedName;
          end
        end
        ModeColon1: begin
          if (char_i == ChColon) begin
            mode_d = ModeColon2;
          end else begin
            hit      = 1'b1;
            err_code = ErrNeedColon;
          end
        end
        ModeColon2: begin
          hit = 1'b1;
          if (char_i == ChEquals) begin
            kind      = KindDone;
            tok_type  = TokAssign;
            text_char = 8'h00;
            res_col   = tok_q;
            mode_d    = ModeIdle;
          end else begin
            err_code = ErrNeedEquals;
          end
        end
        ModeTerm: begin
          if (char_i == ChQuote) begin
            hit       = 1'b1;
            kind      = KindDone;
            tok_type  = TokTerm;
            text_char = 8'h00;
            res_col   = tok_q;
            mode_d    = ModeIdle;
          end else if (char_i >= ChSpace && char_i <= ChTilde) begin
            if (char_i == ChBslash) begin
              mode_d = ModeEscape;
            end else begin
              hit      = 1'b1;
              kind     = KindText;
              tok_type = TokTerm;
              res_col  = tok_q;
            end
          end else begin
            hit      = 1'b1;
            err_code = ErrNeedPrint;
          end
        end
        ModeEscape: begin
          hit = 1'b1;
          if (char_i == ChQuote) begin
            kind     = KindText;
            tok_type = TokTerm;
            res_col  = tok_q;
            mode_d   = ModeTerm;
          end else begin
            err_code = ErrBadEscape;
          end
        end
        default: begin
          mode_d = ModeIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      line_q <= PosBits'(1);
      col_q  <= '0;
      tok_q  <= '0;
    end else if (adv_i) begin
      mode_q <= mode_d;
      line_q <= line_d;
      col_q  <= col_d;
      tok_q  <= tok_d;
    end
  end

  assign res_valid_o      = hit;
  assign res_o.kind       = kind;
  assign res_o.tok_type   = tok_type;
  assign res_o.text_char  = text_char;
  assign res_o.err_code   = err_code;
  assign res_o.line       = OutPosBits'(line_q);
  assign res_o.column     = OutPosBits'(res_col);

  // line count starts at one and only saturates, never wraps to zero
  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q != '0) else $error("line count reached zero");

  a_eoi_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && eoi_i |=> mode_q == ModeIdle && line_q == PosBits'(1) && col_q == '0)
    else $error("end of input did not restore reset state");

  a_text_in_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit && kind == KindText |-> mode_q == ModeNtStart || mode_q == ModeNt ||
                                mode_q == ModeTerm || mode_q == ModeEscape)
    else $error("token text outside a token");

  a_eoi_idle_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eoi_i && mode_q == ModeIdle |-> !hit)
    else $error("error raised at end of input in idle");

endmodule

### rtl/bgl_out_stage.sv
// Result register of the lexer: holds one result until the sink takes it.
// Depends on bgl_pkg for result_t.
module bgl_out_stage import bgl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,      // core result written this cycle
  input  result_t res_i,
  output logic    free_o,      // register can take a result this cycle
  output logic    valid_o,
  input  logic    ready_i,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

### rtl/bnf_grammar_lexer.sv
// BNF grammar lexer top level, depends on bgl_pkg and the bgl_* stages. A byte
// accepted into the input register passes through the core to the result register.
// Throughput: one byte per cycle while the result register is free, set by the
// single-pass state update in the core between the input and result registers.
// Bytes without a result use a core step too. Reset (rst_ni low, async) empties
// both registers and puts the lexer in idle with line 1, column 0.
module bnf_grammar_lexer import bgl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] in_char
  input  logic                 s_axis_tuser,   // [0] end_of_input
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [TdataBits-1:0] m_axis_tdata,   // [2:0] token_type, [10:3] text_char,
                                               // [13:11] error_code, [29:14] line_number,
                                               // [45:30] column_number, rest zero
  output logic [1:0]           m_axis_tuser    // [1:0] event_kind
);

  logic       in_valid;
  logic [7:0] in_char;
  logic       in_eoi;
  logic       adv;
  logic       res_valid;
  result_t    res;
  logic       out_free;
  result_t    out_res;

  assign adv = in_valid && out_free;

  bgl_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .char_i  (s_axis_tdata),
    .eoi_i   (s_axis_tuser),
    .take_i  (adv),
    .valid_o (in_valid),
    .char_o  (in_char),
    .eoi_o   (in_eoi)
  );

  bgl_lex_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .char_i      (in_char),
    .eoi_i       (in_eoi),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  bgl_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (adv && res_valid),
    .res_i   (res),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (out_res)
  );

  assign m_axis_tdata = TdataBits'({out_res.column, out_res.line, out_res.err_code,
                                    out_res.text_char, out_res.tok_type});
  assign m_axis_tuser = out_res.kind;

endmodule
